// ----- hdl/mpts_pkg.sv -----
// ----------------------------------------------------------------------------
// mpts_pkg
// Shared codes and types for the task scheduler and its table cells.
// ----------------------------------------------------------------------------
package mpts_pkg;

	localparam logic [2:0] POL_RR   = 3'd0;
	localparam logic [2:0] POL_FCFS = 3'd1;
	localparam logic [2:0] POL_SJF  = 3'd2;
	localparam logic [2:0] POL_SRTF = 3'd3;
	localparam logic [2:0] POL_PRIO = 3'd4;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ----- hdl/multi_policy_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler
// Task table as a ring of cells; ticks pick a task by the configured policy.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        in         in_valid / in_ready   command, burst_ticks, task_priority
// out       out        out_valid / out_ready add_accepted, has_task, task_index
// cfg       in         apb psel/penable      policy_mode at address 0
//
// add, and tick under round robin or fcfs or on an empty table: result registered
// directly; tick under shortest job, shortest remaining or priority: scan state
// for one full rotation of the cell ring past the head comparator, then the done state
// one request in flight; a new one is taken as the result leaves
// reset clears control state only; table entries hold garbage until written
module multi_policy_task_scheduler #(
	parameter int MAX_TASKS  = 256,
	parameter int TICK_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] burst_ticks,
	input  logic [7:0]  task_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        add_accepted,
	output logic        has_task,
	output logic [7:0]  task_index
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int KW = (TICK_WIDTH > PRIO_WIDTH) ? TICK_WIDTH : PRIO_WIDTH;
	localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

	mpts_pkg::state_t state_q;
	logic [2:0]    policy_q;
	logic [CW-1:0] count_q;
	logic          cur_valid_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] sidx_q;
	logic          found_q;
	logic          keep_q;
	logic [KW-1:0] best_key_q;
	logic [IW-1:0] best_q;
	logic          out_valid_q;
	logic          out_add_q;
	logic          out_has_q;
	logic [7:0]    out_idx_q;

	logic [TICK_WIDTH-1:0] c_burst [MAX_TASKS];
	logic [TICK_WIDTH-1:0] c_rem   [MAX_TASKS];
	logic [PRIO_WIDTH-1:0] c_prio  [MAX_TASKS];

	// apb
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {29'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= mpts_pkg::POL_RR;
		end else if (cfg_wr) begin
			policy_q <= pwdata[2:0];
		end
	end

	logic in_fire, add_fire, tick_fire, full, scan_pol, wear_pol, out_set;
	assign in_ready  = (state_q == mpts_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign full      = (count_q == CW'(MAX_TASKS));
	assign add_fire  = in_fire && (command == mpts_pkg::CMD_ADD) && !full;
	assign tick_fire = in_fire && (command == mpts_pkg::CMD_TICK);
	assign wear_pol  = (policy_q == mpts_pkg::POL_SJF) || (policy_q == mpts_pkg::POL_SRTF);
	assign scan_pol  = wear_pol || (policy_q == mpts_pkg::POL_PRIO);
	// result is ready at once unless the request starts a scan; a scan's result is set in the done state
	assign out_set   = (state_q == mpts_pkg::ST_DONE) ||
	                   (in_fire && !(tick_fire && count_q != '0 && scan_pol));

	// head of the ring, with the running task worn as it passes
	logic          at_cur, in_range, eligible, better;
	logic [TICK_WIDTH-1:0] rem_w;
	logic [KW-1:0] key;
	assign at_cur   = cur_valid_q && (sidx_q == cur_q);
	assign rem_w    = (wear_pol && at_cur && c_rem[0] != '0) ? c_rem[0] - 1'b1 : c_rem[0];
	assign in_range = CW'(sidx_q) < count_q;
	assign eligible = in_range && ((policy_q == mpts_pkg::POL_PRIO) || rem_w != '0);

	always_comb begin
		case (policy_q)
			mpts_pkg::POL_SJF:  key = KW'(c_burst[0]);
			mpts_pkg::POL_SRTF: key = KW'(rem_w);
			default:            key = KW'(c_prio[0]);
		endcase
	end
	assign better = eligible && (!found_q || key < best_key_q);

	genvar g;
	generate
		for (g = 0; g < MAX_TASKS; g++) begin : g_cell
			mpts_pkg::cell_ctl_t ctl;
			assign ctl.shift = (state_q == mpts_pkg::ST_SCAN);
			assign ctl.load  = add_fire && (count_q == CW'(g));
			if (g == MAX_TASKS - 1) begin : g_wrap
				mpts_cell #(.TW(TICK_WIDTH), .PW(PRIO_WIDTH)) u_cell (
					.clk(clk), .ctl(ctl),
					.load_burst(TICK_WIDTH'(burst_ticks)),
					.load_prio(PRIO_WIDTH'(task_priority)),
					.nxt_burst(c_burst[0]), .nxt_rem(rem_w), .nxt_prio(c_prio[0]),
					.burst_q(c_burst[g]), .rem_q(c_rem[g]), .prio_q(c_prio[g])
				);
			end else begin : g_mid
				mpts_cell #(.TW(TICK_WIDTH), .PW(PRIO_WIDTH)) u_cell (
					.clk(clk), .ctl(ctl),
					.load_burst(TICK_WIDTH'(burst_ticks)),
					.load_prio(PRIO_WIDTH'(task_priority)),
					.nxt_burst(c_burst[g+1]), .nxt_rem(c_rem[g+1]),
					.nxt_prio(c_prio[g+1]),
					.burst_q(c_burst[g]), .rem_q(c_rem[g]), .prio_q(c_prio[g])
				);
			end
		end
	endgenerate

	logic [IW+7:0] cur_ext, best_ext, rr_ext, zero_ext;
	logic [IW-1:0] rr_next;
	assign zero_ext = '0;
	assign rr_next  = (CW'(cur_q) + 1'b1 == count_q) ? '0 : cur_q + 1'b1;
	assign rr_ext   = zero_ext | (IW+8)'(rr_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpts_pkg::ST_IDLE;
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			sidx_q      <= '0;
			found_q     <= 1'b0;
			keep_q      <= 1'b0;
			best_key_q  <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			out_add_q   <= 1'b0;
			out_has_q   <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				mpts_pkg::ST_IDLE: begin
					if (in_fire) begin
						if (command == mpts_pkg::CMD_ADD) begin
							out_add_q   <= !full;
							out_has_q   <= 1'b0;
							out_idx_q   <= '0;
							if (!full) count_q <= count_q + 1'b1;
						end else if (count_q == '0) begin
							out_add_q   <= 1'b0;
							out_has_q   <= 1'b0;
							out_idx_q   <= '0;
						end else if (scan_pol) begin
							state_q <= mpts_pkg::ST_SCAN;
							sidx_q  <= '0;
							found_q <= 1'b0;
							keep_q  <= 1'b0;
						end else begin
							out_add_q   <= 1'b0;
							out_has_q   <= 1'b1;
							cur_valid_q <= 1'b1;
							if (policy_q == mpts_pkg::POL_FCFS) begin
								if (!cur_valid_q) cur_q <= '0;
								out_idx_q <= cur_valid_q ? cur_ext[7:0] : 8'd0;
							end else begin
								cur_q     <= cur_valid_q ? rr_next : '0;
								out_idx_q <= cur_valid_q ? rr_ext[7:0] : 8'd0;
							end
						end
					end
				end
				mpts_pkg::ST_SCAN: begin
					if (better) begin
						found_q    <= 1'b1;
						best_key_q <= key;
						best_q     <= sidx_q;
					end
					if (at_cur && rem_w != '0) keep_q <= 1'b1;
					sidx_q <= sidx_q + 1'b1;
					if (sidx_q == LAST) state_q <= mpts_pkg::ST_DONE;
				end
				mpts_pkg::ST_DONE: begin
					state_q     <= mpts_pkg::ST_IDLE;
					out_add_q   <= 1'b0;
					if (policy_q == mpts_pkg::POL_SJF && keep_q) begin
						out_has_q <= 1'b1;
						out_idx_q <= cur_ext[7:0];
					end else if (found_q) begin
						out_has_q   <= 1'b1;
						out_idx_q   <= best_ext[7:0];
						cur_q       <= best_q;
						cur_valid_q <= 1'b1;
					end else begin
						out_has_q <= 1'b0;
						out_idx_q <= '0;
					end
				end
				default: state_q <= mpts_pkg::ST_IDLE;
			endcase
		end
	end

	assign cur_ext  = zero_ext | (IW+8)'(cur_q);
	assign best_ext = zero_ext | (IW+8)'(best_q);

	assign out_valid    = out_valid_q;
	assign add_accepted = out_add_q;
	assign has_task     = out_has_q;
	assign task_index   = out_idx_q;

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpts_pkg::ST_SCAN |-> count_q != '0)
		else $error("scan with empty table");
	a_scan_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mpts_pkg::ST_IDLE |-> !in_ready)
		else $error("request taken during scan");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_add_q && out_has_q))
		else $error("result flags both add and tick");
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> CW'(cur_q) < count_q)
		else $error("current task beyond table");

endmodule

// ----- hdl/mpts_cell.sv -----
// ----------------------------------------------------------------------------
// mpts_cell
// One table entry; loads a new task or takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module mpts_cell #(
	parameter int TW = 16,
	parameter int PW = 8
) (
	input  logic               clk,
	input  mpts_pkg::cell_ctl_t ctl,
	input  logic [TW-1:0]      load_burst,
	input  logic [PW-1:0]      load_prio,
	input  logic [TW-1:0]      nxt_burst,
	input  logic [TW-1:0]      nxt_rem,
	input  logic [PW-1:0]      nxt_prio,
	output logic [TW-1:0]      burst_q,
	output logic [TW-1:0]      rem_q,
	output logic [PW-1:0]      prio_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			burst_q <= load_burst;
			rem_q   <= load_burst;
			prio_q  <= load_prio;
		end else if (ctl.shift) begin
			burst_q <= nxt_burst;
			rem_q   <= nxt_rem;
			prio_q  <= nxt_prio;
		end
	end

endmodule
